/* sv/tspb_pkg.sv */
// shared types, constants and helpers for the tcp probe header builder
// no dependencies; imported by every module of the block
package tspb_pkg;

  localparam int WordW    = 32;
  localparam int HalfW    = 16;
  localparam int KindW    = 3;
  localparam int IdxW     = 3;
  localparam int FlagW    = 6;
  localparam int PsumW    = 19;  // 4 halves plus constant
  localparam int SumW     = 20;  // 10 halves plus constant
  localparam int FoldW    = 17;
  localparam int QDepth   = 2;
  localparam int QPtrW    = 1;
  localparam int QCntW    = 2;

  localparam logic [HalfW-1:0] WindowReset = 16'd5840;
  localparam logic [3:0]       DataOffset  = 4'd5;
  localparam logic [PsumW-1:0] PseudoConst = 19'd26;  // protocol 6 plus length 20

  localparam logic [IdxW-1:0] WordPorts  = 3'd0;
  localparam logic [IdxW-1:0] WordSeq    = 3'd1;
  localparam logic [IdxW-1:0] WordAck    = 3'd2;
  localparam logic [IdxW-1:0] WordCtl    = 3'd3;
  localparam logic [IdxW-1:0] WordCsum   = 3'd4;

  localparam logic [KindW-1:0] KindSyn  = 3'd0;
  localparam logic [KindW-1:0] KindAck  = 3'd1;
  localparam logic [KindW-1:0] KindFin  = 3'd2;
  localparam logic [KindW-1:0] KindXmas = 3'd3;

  localparam logic [FlagW-1:0] FlagFin = 6'h01;
  localparam logic [FlagW-1:0] FlagSyn = 6'h02;
  localparam logic [FlagW-1:0] FlagPsh = 6'h08;
  localparam logic [FlagW-1:0] FlagAck = 6'h10;
  localparam logic [FlagW-1:0] FlagUrg = 6'h20;

  typedef struct packed {
    logic [HalfW-1:0] source_port;
    logic [HalfW-1:0] target_port;
    logic [WordW-1:0] sequence_number;
    logic [FlagW-1:0] flags;
    logic [PsumW-1:0] psum;
  } probe_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [FlagW-1:0] kind_flags(input logic [KindW-1:0] kind);
    logic [FlagW-1:0] f;
    case (kind)
      KindSyn:  f = FlagSyn;
      KindAck:  f = FlagAck;
      KindFin:  f = FlagFin;
      KindXmas: f = FlagFin | FlagPsh | FlagUrg;
      default:  f = '0;
    endcase
    return f;
  endfunction

endpackage

/* sv/tspb_front.sv */
// front end: takes probe requests, maps scan kind to flags and sums the pseudo-header
// depends on tspb_pkg
module tspb_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [31:0]                 source_address,
  input  logic [31:0]                 target_address,
  input  logic [15:0]                 source_port,
  input  logic [15:0]                 target_port,
  input  logic [31:0]                 sequence_number,
  input  logic [2:0]                  scan_kind,
  input  tspb_pkg::q_status_t         q_status,
  output logic                        push,
  output tspb_pkg::probe_t            push_data
);
  import tspb_pkg::*;

  logic   f_valid;
  probe_t f_entry;
  logic   accept;
  logic [PsumW-1:0] psum_next;

  assign busy   = f_valid && q_status.full;
  assign accept = start && !busy;
  assign push   = f_valid && !q_status.full;
  assign push_data = f_entry;

  assign psum_next = PsumW'(source_address[31:16]) + PsumW'(source_address[15:0])
                   + PsumW'(target_address[31:16]) + PsumW'(target_address[15:0])
                   + PseudoConst;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry.source_port     <= source_port;
      f_entry.target_port     <= target_port;
      f_entry.sequence_number <= sequence_number;
      f_entry.flags           <= kind_flags(scan_kind);
      f_entry.psum            <= psum_next;
    end
  end

endmodule

/* sv/tspb_queue.sv */
// two-entry request queue between front and back
// depends on tspb_pkg
module tspb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tspb_pkg::probe_t    push_data,
  input  logic                pop,
  output tspb_pkg::probe_t    head,
  output tspb_pkg::q_status_t status
);
  import tspb_pkg::*;

  probe_t            mem [QDepth];
  logic [QPtrW-1:0]  wr_ptr;
  logic [QPtrW-1:0]  rd_ptr;
  logic [QCntW-1:0]  count;

  assign status.full  = (count == QCntW'(QDepth));
  assign status.empty = (count == '0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/tspb_back.sv */
// back end: walks the five header words of the head request and finishes the checksum
// depends on tspb_pkg
module tspb_back (
  input  logic                clk,
  input  logic                rst,
  input  tspb_pkg::probe_t    head,
  input  tspb_pkg::q_status_t q_status,
  input  logic [15:0]         window_size,
  output logic                pop,
  output logic                valid,
  output logic [31:0]         header_word,
  output logic [2:0]          word_index,
  output logic                last_word
);
  import tspb_pkg::*;

  logic              active;
  logic [IdxW-1:0]   idx;
  logic [SumW-1:0]   sum_r;
  logic [FoldW-1:0]  fold_r;
  logic [HalfW-1:0]  ck_r;
  logic [HalfW-1:0]  ctl_half;
  logic [SumW-1:0]   sum_next;
  logic [WordW-1:0]  word;

  assign active   = !q_status.empty;
  assign pop      = active && (idx == WordCsum);
  assign ctl_half = {DataOffset, 6'b0, head.flags};

  assign sum_next = SumW'(head.psum)
                  + SumW'(head.source_port) + SumW'(head.target_port)
                  + SumW'(head.sequence_number[31:16]) + SumW'(head.sequence_number[15:0])
                  + SumW'(ctl_half) + SumW'(window_size);

  always_comb begin
    case (idx)
      WordPorts: word = {head.source_port, head.target_port};
      WordSeq:   word = head.sequence_number;
      WordAck:   word = '0;
      WordCtl:   word = {ctl_half, window_size};
      WordCsum:  word = {ck_r, 16'h0000};
      default:   word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= WordPorts;
      valid <= 1'b0;
    end else begin
      valid <= active;
      if (active) begin
        idx <= (idx == WordCsum) ? WordPorts : idx + 1'b1;
      end
    end
  end

  // checksum folds over the first three words of each header
  always_ff @(posedge clk) begin
    if (active) begin
      header_word <= word;
      word_index  <= idx;
      last_word   <= (idx == WordCsum);
      if (idx == WordPorts) begin
        sum_r <= sum_next;
      end
      if (idx == WordSeq) begin
        fold_r <= FoldW'(sum_r[15:0]) + FoldW'(sum_r[19:16]);
      end
      if (idx == WordAck) begin
        ck_r <= ~(fold_r[15:0] + HalfW'(fold_r[16]));
      end
    end
  end

endmodule

/* sv/tcp_scan_probe_header_builder_core.sv */
// top level of the tcp probe header builder
// depends on tspb_pkg, tspb_front, tspb_queue, tspb_back
//
// usage:
//   a probe request (addresses, ports, sequence number, scan kind) is taken
//   at a clock edge where start is high and busy is low.
//   each request yields five 32-bit header words in network order, one per
//   cycle on header_word, with word_index 0..4 and last_word on word 4,
//   each marked by valid for exactly one cycle. the receiver cannot stall.
//   word 0 passes through the front register, a queue entry and the back
//   end's output register; the five words then follow on consecutive cycles.
//   the back end has a single-word output path and finishes one header
//   before it starts the next. a front register and a two-entry queue let
//   requests be taken back to back until they fill; busy then holds.
//   window_size is written through window_we / window_wdata; the user must
//   do so only while idle, the block does not enforce it. synchronous reset
//   (rst) empties the queue, drops pending requests and sets window to 5840.
//
module tcp_scan_probe_header_builder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_address,
  input  logic [31:0] target_address,
  input  logic [15:0] source_port,
  input  logic [15:0] target_port,
  input  logic [31:0] sequence_number,
  input  logic [2:0]  scan_kind,
  input  logic        window_we,
  input  logic [15:0] window_wdata,
  output logic        valid,
  output logic [31:0] header_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import tspb_pkg::*;

  logic [HalfW-1:0] window_size;
  q_status_t        q_status;
  logic             push;
  logic             pop;
  probe_t           push_data;
  probe_t           head;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WindowReset;
    end else if (window_we) begin
      window_size <= window_wdata;
    end
  end

  tspb_front u_front (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .source_address  (source_address),
    .target_address  (target_address),
    .source_port     (source_port),
    .target_port     (target_port),
    .sequence_number (sequence_number),
    .scan_kind       (scan_kind),
    .q_status        (q_status),
    .push            (push),
    .push_data       (push_data)
  );

  tspb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  tspb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .window_size (window_size),
    .pop         (pop),
    .valid       (valid),
    .header_word (header_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

  // words of one header come out on consecutive cycles
  a_word_seq: assert property (@(posedge clk) disable iff (rst)
    valid && !last_word |=> valid && (word_index == $past(word_index) + 3'd1))
    else $error("header words not consecutive");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    valid |-> (last_word == (word_index == WordCsum)))
    else $error("last_word out of place");

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> q_status.full && !q_status.empty)
    else $error("busy without full queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule
